[src/pls_pkg.sv]
// Shared constants, command codes and controller/datapath interface types.
package pls_pkg;

  localparam int CAPACITY = 64;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int GRP      = 8;
  localparam int GRP_W    = $clog2(GRP);
  localparam int NUM_GRP  = (CAPACITY + GRP - 1) / GRP;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  typedef struct packed {
    logic load;
    logic do_insert;
    logic do_remove;
    logic do_clear;
    logic capture;
    logic is_read;
  } dp_cmd_t;

  typedef struct packed {
    logic ins_ok;
    logic pos_live;
    logic found;
  } dp_sts_t;

endpackage

[src/pls_datapath.sv]
// Cell chain, count register, search and read select stages of the list store.
module pls_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pls_pkg::dp_cmd_t            dp_cmd_i,
  input  logic [pls_pkg::POS_W-1:0]   position_i,
  input  logic [pls_pkg::VAL_W-1:0]   value_i,
  output pls_pkg::dp_sts_t            dp_sts_o,
  output logic [pls_pkg::VAL_W-1:0]   read_value_o,
  output logic [pls_pkg::COUNT_W-1:0] count_o
);

  logic [pls_pkg::VAL_W-1:0] cell_q   [pls_pkg::CAPACITY];
  logic [pls_pkg::VAL_W-1:0] cell_d   [pls_pkg::CAPACITY];
  logic [pls_pkg::VAL_W-1:0] up_src   [pls_pkg::CAPACITY];
  logic [pls_pkg::VAL_W-1:0] down_src [pls_pkg::CAPACITY];
  logic [pls_pkg::VAL_W-1:0] cell_pad [pls_pkg::NUM_GRP*pls_pkg::GRP];
  logic [pls_pkg::VAL_W-1:0] grp_q    [pls_pkg::NUM_GRP];
  logic [pls_pkg::VAL_W-1:0] grp_d    [pls_pkg::NUM_GRP];
  logic [pls_pkg::VAL_W-1:0] sel_val;
  logic [pls_pkg::VAL_W-1:0] read_value_q, read_value_d;
  logic [pls_pkg::POS_W-1:0] pos_q;
  logic [pls_pkg::VAL_W-1:0] val_q;
  logic [pls_pkg::CNT_W-1:0] count_q, count_d;
  logic [pls_pkg::CAPACITY-1:0] match_q, match_d;
  logic [pls_pkg::CMP_W-1:0] pos_ext, cnt_ext, pos_hi;

  assign pos_ext = pls_pkg::CMP_W'(pos_q);
  assign cnt_ext = pls_pkg::CMP_W'(count_q);
  assign pos_hi  = pls_pkg::CMP_W'(pos_q >> pls_pkg::GRP_W);

  assign dp_sts_o.ins_ok   = (cnt_ext < pls_pkg::CMP_W'(pls_pkg::CAPACITY)) &&
                             (pos_ext <= cnt_ext);
  assign dp_sts_o.pos_live = pos_ext < cnt_ext;
  assign dp_sts_o.found    = |match_q;

  genvar gi;
  generate
    for (gi = 0; gi < pls_pkg::CAPACITY; gi++) begin : g_cell
      if (gi > 0) begin : g_up
        assign up_src[gi] = cell_q[gi-1];
      end else begin : g_up0
        assign up_src[gi] = cell_q[gi];
      end
      if (gi < pls_pkg::CAPACITY - 1) begin : g_dn
        assign down_src[gi] = cell_q[gi+1];
      end else begin : g_dn_last
        assign down_src[gi] = cell_q[gi];
      end

      always_comb begin
        cell_d[gi] = cell_q[gi];
        if (dp_cmd_i.do_insert) begin
          if (pls_pkg::CMP_W'(gi) == pos_ext) begin
            cell_d[gi] = val_q;
          end else if (pls_pkg::CMP_W'(gi) > pos_ext) begin
            cell_d[gi] = up_src[gi];
          end
        end else if (dp_cmd_i.do_remove) begin
          if (pls_pkg::CMP_W'(gi) >= pos_ext) begin
            cell_d[gi] = down_src[gi];
          end
        end
      end

      assign match_d[gi] = (cell_q[gi] == val_q) && (pls_pkg::CMP_W'(gi) < cnt_ext);
    end

    for (gi = 0; gi < pls_pkg::NUM_GRP * pls_pkg::GRP; gi++) begin : g_pad
      if (gi < pls_pkg::CAPACITY) begin : g_live
        assign cell_pad[gi] = cell_q[gi];
      end else begin : g_zero
        assign cell_pad[gi] = '0;
      end
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < pls_pkg::NUM_GRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < pls_pkg::GRP; k++) begin
        if (pos_q[pls_pkg::GRP_W-1:0] == pls_pkg::GRP_W'(k)) begin
          grp_d[g] = cell_pad[g*pls_pkg::GRP + k];
        end
      end
    end
  end

  always_comb begin
    sel_val = '0;
    for (int g = 0; g < pls_pkg::NUM_GRP; g++) begin
      if (pos_hi == pls_pkg::CMP_W'(g)) begin
        sel_val = grp_q[g];
      end
    end
  end

  always_comb begin
    if (!dp_cmd_i.is_read) begin
      read_value_d = '0;
    end else if (dp_sts_o.pos_live) begin
      read_value_d = sel_val;
    end else begin
      read_value_d = '1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (dp_cmd_i.do_clear) begin
      count_d = '0;
    end else if (dp_cmd_i.do_insert) begin
      count_d = count_q + 1'b1;
    end else if (dp_cmd_i.do_remove) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < pls_pkg::CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
    match_q <= match_d;
    for (int g = 0; g < pls_pkg::NUM_GRP; g++) begin
      grp_q[g] <= grp_d[g];
    end
    if (dp_cmd_i.load) begin
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (dp_cmd_i.capture) begin
      read_value_q <= read_value_d;
    end
  end

  assign read_value_o = read_value_q;
  assign count_o      = pls_pkg::COUNT_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.do_insert |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the list by one");

endmodule

[src/pls_ctrl.sv]
// Command sequencer of the list store: accept, execute, reduce, respond.
module pls_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [pls_pkg::CMD_W-1:0] cmd_i,
  input  pls_pkg::dp_sts_t          dp_sts_i,
  output pls_pkg::dp_cmd_t          dp_cmd_o,
  output logic                      busy,
  output logic                      done_o,
  output logic                      ok_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_REDUCE = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [pls_pkg::CMD_W-1:0] cmd_q;
  logic                      ok_q, ok_d;
  logic                      accept;

  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ok_d    = ok_q;
    dp_cmd_o = '0;
    dp_cmd_o.load = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_REDUCE;
        unique case (cmd_q)
          pls_pkg::CMD_INSERT: begin
            ok_d = dp_sts_i.ins_ok;
            dp_cmd_o.do_insert = dp_sts_i.ins_ok;
          end
          pls_pkg::CMD_REMOVE: begin
            ok_d = dp_sts_i.pos_live;
            dp_cmd_o.do_remove = dp_sts_i.pos_live;
          end
          pls_pkg::CMD_READ: ok_d = dp_sts_i.pos_live;
          pls_pkg::CMD_CLEAR: begin
            ok_d = 1'b1;
            dp_cmd_o.do_clear = 1'b1;
          end
          default: ok_d = 1'b0;
        endcase
      end
      ST_REDUCE: begin
        state_d = ST_RESP;
        dp_cmd_o.capture = 1'b1;
        dp_cmd_o.is_read = (cmd_q == pls_pkg::CMD_READ);
        if (cmd_q == pls_pkg::CMD_FIND) begin
          ok_d = dp_sts_i.found;
        end
      end
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    ok_q <= ok_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);
  assign ok_o   = ok_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !done_o)
    else $error("accepted request did not start execution");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe held longer than one cycle");

  a_shift_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd_o.do_insert, dp_cmd_o.do_remove, dp_cmd_o.do_clear}))
    else $error("conflicting list updates");

endmodule

[src/positional_list_store_top.sv]
// Top level of the bounded positional list store.
// A request runs from acceptance to the next possible acceptance through the states execute
// (the cell chain shifts the whole list at once on insert or remove), reduce (the find
// compare is reduced and the two-level read select finished), respond (the result is
// shown) and idle, at whose end the next request is taken.
// Results appear on done_o for exactly one cycle and cannot be stalled; busy is high
// from the cycle after acceptance until the result has been shown.
module positional_list_store_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pls_pkg::CMD_W-1:0]   cmd_i,
  input  logic [pls_pkg::POS_W-1:0]   position_i,
  input  logic [pls_pkg::VAL_W-1:0]   value_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [pls_pkg::VAL_W-1:0]   read_value_o,
  output logic [pls_pkg::COUNT_W-1:0] count_o
);

  pls_pkg::dp_cmd_t dp_cmd;
  pls_pkg::dp_sts_t dp_sts;

  pls_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .dp_sts_i (dp_sts),
    .dp_cmd_o (dp_cmd),
    .busy     (busy),
    .done_o   (done_o),
    .ok_o     (ok_o)
  );

  pls_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_cmd_i     (dp_cmd),
    .position_i   (position_i),
    .value_i      (value_i),
    .dp_sts_o     (dp_sts),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

endmodule
